// ===== rtl/smooth_vertex_normal_accumulator_assert.svh =====
// Assertion macros used by the checker of the normal accumulator.
`ifndef SMOOTH_VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH
`define SMOOTH_VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVA_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle port rule violated");

// Next-cycle implication, disabled while reset is asserted.
`define SVA_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle port rule violated");

`endif

// ===== rtl/smva_pkg.sv =====
// Shared constants, command codes and transfer types of the normal accumulator.
package smva_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);

    localparam logic [1:0] K_WRITE = 2'd0;
    localparam logic [1:0] K_TRI   = 2'd1;
    localparam logic [1:0] K_READ  = 2'd2;
    localparam logic [1:0] K_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [11:0]        vtx_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [11:0]        corner_a;
        logic [11:0]        corner_b;
        logic [11:0]        corner_c;
    } t_in_item;

    typedef struct packed {
        logic [11:0]        vertex_out;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               zero_normal;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_pos;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
    } t_acc;

endpackage

// ===== rtl/smooth_vertex_normal_accumulator.sv =====
// Smooth vertex normal accumulator: position store, face normals, per-vertex sums.
//
//   channel   | direction | handshake                | payload
//   ----------+-----------+--------------------------+-------------------------
//   command   | in        | start high, busy low     | i_item   (t_in_item)
//   result    | out       | o_done for one cycle     | o_result (t_out_item)
//
// Position write: busy stays low. Out-of-range read: result the next cycle.
// Triangle and in-range read: busy high (shorter for a degenerate face or a zero
// accumulator), result strobe of a read in the first idle cycle. The work is done by
// the one-bit-per-cycle normalizing shifter, the square root (32 steps) and the
// restoring divider (a load and 15 steps per component) on the shared datapath with
// its single multiplier.
// Reset and clear run a clearing pass over every entry of the accumulator memory,
// with busy high. The receiver cannot stall: each result is shown for one cycle only.
module smooth_vertex_normal_accumulator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  smva_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_done,
    output smva_pkg::t_out_item o_result
);
    import smva_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_PRD   = 4'd2;
    localparam logic [3:0] S_EMAG  = 4'd3;
    localparam logic [3:0] S_ESH   = 4'd4;
    localparam logic [3:0] S_CROSS = 4'd5;
    localparam logic [3:0] S_LDACC = 4'd6;
    localparam logic [3:0] S_NMAG  = 4'd7;
    localparam logic [3:0] S_NSH   = 4'd8;
    localparam logic [3:0] S_SQ    = 4'd9;
    localparam logic [3:0] S_SQRT  = 4'd10;
    localparam logic [3:0] S_DLD   = 4'd11;
    localparam logic [3:0] S_DIV   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;
    localparam logic [3:0] S_ACRD  = 4'd14;
    localparam logic [3:0] S_ACWR  = 4'd15;

    // control state
    logic [3:0]        r_state, n_state;
    logic [4:0]        r_cnt, n_cnt;
    logic [1:0]        r_j, n_j;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              r_done, n_done;

    // datapath
    logic                r_tri;
    logic [11:0]         r_vidx, r_ca, r_cb, r_cc;
    t_pos                r_pa;
    logic signed [32:0]  r_e [6];
    logic [63:0]         r_m;
    logic signed [63:0]  r_v [3];
    logic [63:0]         r_prod;
    logic [63:0]         r_sum;
    logic [63:0]         r_rt;
    logic [63:0]         r_bit;
    logic [46:0]         r_num, r_den;
    logic [14:0]         r_q;
    logic signed [15:0]  r_n [3];
    t_out_item           r_res;

    // memories
    t_pos r_pos_mem [MAX_VERTICES];
    t_pos r_pos_rd;
    t_acc r_acc_mem [MAX_VERTICES];
    t_acc r_acc_rd;

    logic [11:0]        w_corner;
    logic               w_accept;
    logic               w_tri_ok;
    logic signed [32:0] w_opa, w_opb;
    logic signed [65:0] w_mul;
    logic [63:0]        w_prod;
    logic [1:0]         w_vi;
    logic signed [63:0] w_vsel;
    logic [31:0]        w_mag;
    logic [63:0]        w_root_t;
    logic               w_qbit;
    logic [14:0]        w_qfin;
    logic [2:0]         w_step;
    logic               w_acc_we;
    logic [ADDR_W-1:0]  w_acc_waddr;
    logic [ADDR_W-1:0]  w_acc_raddr;
    t_acc               w_acc_wdata;
    t_pos               w_pos_wr;

    function automatic logic idx_ok(input logic [11:0] idx);
        return 32'(idx) < 32'(MAX_VERTICES);
    endfunction

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [32:0] sub33(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return 33'(a) - 33'(b);
    endfunction

    function automatic logic signed [23:0] sat_add(input logic signed [23:0] a,
                                                   input logic signed [15:0] b);
        logic signed [24:0] s;
        s = 25'(a) + 25'(b);
        if (s[24] != s[23]) begin
            return s[24] ? 24'sh800000 : 24'sh7FFFFF;
        end
        return s[23:0];
    endfunction

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;
    assign w_accept = start && !busy;
    assign w_tri_ok = idx_ok(i_item.corner_a) && idx_ok(i_item.corner_b)
                      && idx_ok(i_item.corner_c);

    // pick the corner for the current step
    always_comb begin
        unique case (r_j)
            2'd0:    w_corner = r_ca;
            2'd1:    w_corner = r_cb;
            default: w_corner = r_cc;
        endcase
    end

    // shared multiplier operands: magnitude to square, else one cross product term
    always_comb begin
        if (r_state == S_SQ) begin
            w_opa = {1'b0, w_mag};
            w_opb = {1'b0, w_mag};
        end else begin
            unique case (r_cnt[2:0])
                3'd0:    begin w_opa = r_e[1]; w_opb = r_e[5]; end
                3'd1:    begin w_opa = r_e[2]; w_opb = r_e[4]; end
                3'd2:    begin w_opa = r_e[2]; w_opb = r_e[3]; end
                3'd3:    begin w_opa = r_e[0]; w_opb = r_e[5]; end
                3'd4:    begin w_opa = r_e[0]; w_opb = r_e[4]; end
                3'd5:    begin w_opa = r_e[1]; w_opb = r_e[3]; end
                default: begin w_opa = r_e[0]; w_opb = r_e[3]; end
            endcase
        end
    end
    assign w_mul  = w_opa * w_opb;
    assign w_prod = w_mul[63:0];
    assign w_step = r_cnt[2:0] - 3'd1;

    // select the vector component for magnitude, square and divide
    assign w_vi = (r_state == S_DLD || r_state == S_DIV) ? r_j : r_cnt[1:0];
    always_comb begin
        unique case (w_vi)
            2'd0:    w_vsel = r_v[0];
            2'd1:    w_vsel = r_v[1];
            default: w_vsel = r_v[2];
        endcase
    end
    assign w_mag    = w_vsel[63] ? (~w_vsel[31:0] + 32'd1) : w_vsel[31:0];
    assign w_root_t = r_rt + r_bit;
    assign w_qbit   = (r_num >= r_den);
    assign w_qfin   = {r_q[13:0], w_qbit};

    // position store: write on a transfer, registered read
    assign w_pos_wr = '{x: i_item.pos_x, y: i_item.pos_y, z: i_item.pos_z};
    always_ff @(posedge i_clk) begin
        if (w_accept && i_item.kind == K_WRITE && idx_ok(i_item.vtx_id)) begin
            r_pos_mem[ADDR_W'(i_item.vtx_id)] <= w_pos_wr;
        end
        r_pos_rd <= r_pos_mem[ADDR_W'(w_corner)];
    end

    // accumulator store: clearing pass and read-modify-write
    assign w_acc_we    = (r_state == S_CLR) || (r_state == S_ACWR);
    assign w_acc_waddr = (r_state == S_CLR) ? r_clr : ADDR_W'(w_corner);
    assign w_acc_raddr = (r_state == S_IDLE) ? ADDR_W'(i_item.vtx_id)
                                             : ADDR_W'(w_corner);
    always_comb begin
        if (r_state == S_CLR) begin
            w_acc_wdata = '0;
        end else begin
            w_acc_wdata = '{x: sat_add(r_acc_rd.x, r_n[0]),
                            y: sat_add(r_acc_rd.y, r_n[1]),
                            z: sat_add(r_acc_rd.z, r_n[2])};
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_acc_we) begin
            r_acc_mem[w_acc_waddr] <= w_acc_wdata;
        end
        r_acc_rd <= r_acc_mem[w_acc_raddr];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_j     = r_j;
        n_clr   = r_clr;
        n_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_item.kind)
                        K_WRITE: ;
                        K_TRI: begin
                            if (w_tri_ok) begin
                                n_state = S_PRD;
                                n_j     = 2'd0;
                            end
                        end
                        K_READ: begin
                            if (idx_ok(i_item.vtx_id)) begin
                                n_state = S_LDACC;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        K_CLEAR: begin
                            n_state = S_CLR;
                            n_clr   = '0;
                        end
                    endcase
                end
            end
            S_CLR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == ADDR_W'(MAX_VERTICES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_PRD: begin
                n_j = r_j + 2'd1;
                if (r_j == 2'd3) begin
                    n_state = S_EMAG;
                    n_cnt   = '0;
                end
            end
            S_EMAG: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd5) begin
                    n_state = S_ESH;
                end
            end
            S_ESH: begin
                if (r_m[63:30] == '0) begin
                    n_state = S_CROSS;
                    n_cnt   = '0;
                end
            end
            S_CROSS: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd6) begin
                    n_state = S_NMAG;
                    n_cnt   = '0;
                end
            end
            S_LDACC: begin
                n_state = S_NMAG;
                n_cnt   = '0;
            end
            S_NMAG: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd2) begin
                    n_state = S_NSH;
                end
            end
            S_NSH: begin
                if (r_m == '0) begin
                    n_state = S_IDLE;
                    n_done  = !r_tri;
                end else if (r_m[63:31] == '0 && r_m[30]) begin
                    n_state = S_SQ;
                    n_cnt   = '0;
                end
            end
            S_SQ: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd3) begin
                    n_state = S_SQRT;
                    n_cnt   = '0;
                end
            end
            S_SQRT: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_DLD;
                    n_j     = 2'd0;
                end
            end
            S_DLD: begin
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DIV: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd14) begin
                    if (r_j == 2'd2) begin
                        n_j     = 2'd0;
                        n_state = r_tri ? S_ACRD : S_OUT;
                    end else begin
                        n_j     = r_j + 2'd1;
                        n_state = S_DLD;
                    end
                end
            end
            S_OUT: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_ACRD: begin
                n_state = S_ACWR;
            end
            S_ACWR: begin
                if (r_j == 2'd2) begin
                    n_state = S_IDLE;
                end else begin
                    n_j     = r_j + 2'd1;
                    n_state = S_ACRD;
                end
            end
        endcase
    end

    // control registers; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_j     <= '0;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_j     <= n_j;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
    end

    // shared datapath: edges, cross product, normalize, root, divide
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_tri  <= (i_item.kind == K_TRI);
                    r_vidx <= i_item.vtx_id;
                    r_ca   <= i_item.corner_a;
                    r_cb   <= i_item.corner_b;
                    r_cc   <= i_item.corner_c;
                    r_res  <= '{vertex_out: i_item.vtx_id, normal_x: '0,
                               normal_y: '0, normal_z: '0, zero_normal: 1'b1};
                end
            end
            S_PRD: begin
                unique case (r_j)
                    2'd0: ;
                    2'd1: r_pa <= r_pos_rd;
                    2'd2: begin
                        r_e[0] <= sub33(r_pos_rd.x, r_pa.x);
                        r_e[1] <= sub33(r_pos_rd.y, r_pa.y);
                        r_e[2] <= sub33(r_pos_rd.z, r_pa.z);
                    end
                    2'd3: begin
                        r_e[3] <= sub33(r_pos_rd.x, r_pa.x);
                        r_e[4] <= sub33(r_pos_rd.y, r_pa.y);
                        r_e[5] <= sub33(r_pos_rd.z, r_pa.z);
                        r_m    <= '0;
                    end
                endcase
            end
            S_EMAG: begin
                r_m <= r_m | 64'(abs33(r_e[r_cnt[2:0]]));
            end
            S_ESH: begin
                // halve all edges until the largest fits in 30 bits
                if (r_m[63:30] != '0) begin
                    for (int i = 0; i < 6; i++) begin
                        r_e[i] <= r_e[i] >>> 1;
                    end
                    r_m <= r_m >> 1;
                end
            end
            S_CROSS: begin
                if (r_cnt < 5'd6) begin
                    r_prod <= w_prod;
                end
                if (r_cnt != 5'd0) begin
                    if (!w_step[0]) begin
                        r_v[w_step[2:1]] <= $signed(r_prod);
                    end else begin
                        r_v[w_step[2:1]] <= r_v[w_step[2:1]] - $signed(r_prod);
                    end
                end
                if (r_cnt == 5'd6) begin
                    r_m <= '0;
                end
            end
            S_LDACC: begin
                r_v[0] <= 64'(r_acc_rd.x);
                r_v[1] <= 64'(r_acc_rd.y);
                r_v[2] <= 64'(r_acc_rd.z);
                r_m    <= '0;
            end
            S_NMAG: begin
                r_m <= r_m | abs64(w_vsel);
            end
            S_NSH: begin
                // bring the largest magnitude into [2^30, 2^31)
                if (r_m[63:31] != '0) begin
                    for (int i = 0; i < 3; i++) begin
                        r_v[i] <= r_v[i] >>> 1;
                    end
                    r_m <= r_m >> 1;
                end else if (r_m != '0 && !r_m[30]) begin
                    for (int i = 0; i < 3; i++) begin
                        r_v[i] <= r_v[i] <<< 1;
                    end
                    r_m <= r_m << 1;
                end else begin
                    r_sum <= '0;
                end
            end
            S_SQ: begin
                if (r_cnt < 5'd3) begin
                    r_prod <= w_prod;
                end
                if (r_cnt != 5'd0) begin
                    r_sum <= r_sum + r_prod;
                end
                if (r_cnt == 5'd3) begin
                    r_rt  <= '0;
                    r_bit <= 64'd1 << 62;
                end
            end
            S_SQRT: begin
                if (r_sum >= w_root_t) begin
                    r_sum <= r_sum - w_root_t;
                    r_rt  <= (r_rt >> 1) + r_bit;
                end else begin
                    r_rt <= r_rt >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_DLD: begin
                r_num <= {1'b0, w_mag, 14'b0} + 47'(r_rt[31:1]);
                r_den <= {1'b0, r_rt[31:0], 14'b0};
                r_q   <= '0;
            end
            S_DIV: begin
                if (w_qbit) begin
                    r_num <= r_num - r_den;
                end
                r_q   <= w_qfin;
                r_den <= r_den >> 1;
                if (r_cnt == 5'd14) begin
                    r_n[r_j] <= w_vsel[63] ? -$signed({1'b0, w_qfin})
                                           : $signed({1'b0, w_qfin});
                end
            end
            S_OUT: begin
                r_res <= '{vertex_out: r_vidx, normal_x: r_n[0], normal_y: r_n[1],
                           normal_z: r_n[2], zero_normal: 1'b0};
            end
            S_CLR, S_ACRD, S_ACWR: ;
        endcase
    end

endmodule

// ===== rtl/smva_checker.sv =====
// Port-level checker for the normal accumulator, bound to the top level.
`include "smooth_vertex_normal_accumulator_assert.svh"

module smva_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input smva_pkg::t_in_item  i_item,
    input logic                busy,
    input logic                o_done,
    input smva_pkg::t_out_item o_result
);
    import smva_pkg::*;

    logic w_comp_zero;
    logic w_comp_range;

    // summarize the result components
    assign w_comp_zero  = o_result.normal_x == 16'sd0 && o_result.normal_y == 16'sd0
                          && o_result.normal_z == 16'sd0;
    assign w_comp_range = o_result.normal_x <= 16'sd16384 && o_result.normal_x >= -16'sd16384
                          && o_result.normal_y <= 16'sd16384
                          && o_result.normal_y >= -16'sd16384
                          && o_result.normal_z <= 16'sd16384
                          && o_result.normal_z >= -16'sd16384;

    // a result is shown only once the block is free again
    `SVA_SAME(a_done_idle, i_clk, i_rst_n, o_done, !busy)

    // a zero-length normal reports zero components
    `SVA_SAME(a_zero_comp, i_clk, i_rst_n, o_done && o_result.zero_normal, w_comp_zero)

    // components stay on the unit sphere range
    `SVA_SAME(a_unit_range, i_clk, i_rst_n, o_done, w_comp_range)

    // a clear transfer starts the clearing pass
    `SVA_NEXT(a_clear_busy, i_clk, i_rst_n, start && !busy && i_item.kind == K_CLEAR, busy)

endmodule

bind smooth_vertex_normal_accumulator smva_checker u_smva_checker (.*);

// ===== verif/smooth_vertex_normal_accumulator_tb.sv =====
// Testbench for the smooth vertex normal accumulator: directed and random commands with a predictor.
module smooth_vertex_normal_accumulator_tb;
    import smva_pkg::*;

    // Predicts read results from its own copy of positions and accumulators
    class normal_scoreboard;
        t_pos      pos_mem[MAX_VERTICES];
        t_acc      acc_mem[MAX_VERTICES];
        t_out_item normal_q[$];
        int        errors;

        function new();
            errors = 0;
            foreach (acc_mem[i]) begin
                acc_mem[i] = '0;
                pos_mem[i] = '0;
            end
        endfunction

        function longint unsigned mag(longint v);
            return (v < 0) ? longint'(-v) : v;
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // Scale to a Q2.14 unit vector; zero vector reports 0
        function bit unit_vec(input longint vx, input longint vy, input longint vz,
                              output logic signed [15:0] nx, output logic signed [15:0] ny,
                              output logic signed [15:0] nz);
            longint          v[3];
            longint          w[3];
            longint unsigned m, sum, len, q;
            int              s;
            logic signed [15:0] o[3];
            v[0] = vx; v[1] = vy; v[2] = vz;
            m = 0;
            sum = 0;
            s = 0;
            for (int i = 0; i < 3; i++) begin
                if (mag(v[i]) > m) m = mag(v[i]);
                o[i] = '0;
            end
            nx = 0; ny = 0; nz = 0;
            if (m == 0) return 0;
            if (m >= (64'd1 << 31)) begin
                while ((m >> s) >= (64'd1 << 31)) s++;
                for (int i = 0; i < 3; i++) w[i] = v[i] >>> s;
            end else begin
                while ((m << s) < (64'd1 << 30)) s++;
                for (int i = 0; i < 3; i++) w[i] = v[i] <<< s;
            end
            for (int i = 0; i < 3; i++) sum += mag(w[i]) * mag(w[i]);
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++) begin
                q = (mag(w[i]) * 64'd16384 + len / 2) / len;
                o[i] = (w[i] < 0) ? -16'(q) : 16'(q);
            end
            nx = o[0]; ny = o[1]; nz = o[2];
            return 1;
        endfunction

        function logic signed [23:0] sat_add(logic signed [23:0] a, logic signed [15:0] b);
            int r;
            r = int'(a) + int'(b);
            if (r > 8388607) r = 8388607;
            if (r < -8388608) r = -8388608;
            return 24'(r);
        endfunction

        function void add_face(int a, int b, int c);
            longint          e1[3], e2[3], cr[3];
            longint unsigned m;
            int              s, k;
            int              idx[3];
            logic signed [15:0] nx, ny, nz;
            e1[0] = longint'(pos_mem[b].x) - pos_mem[a].x;
            e1[1] = longint'(pos_mem[b].y) - pos_mem[a].y;
            e1[2] = longint'(pos_mem[b].z) - pos_mem[a].z;
            e2[0] = longint'(pos_mem[c].x) - pos_mem[a].x;
            e2[1] = longint'(pos_mem[c].y) - pos_mem[a].y;
            e2[2] = longint'(pos_mem[c].z) - pos_mem[a].z;
            m = 0;
            s = 0;
            for (int i = 0; i < 3; i++) begin
                if (mag(e1[i]) > m) m = mag(e1[i]);
                if (mag(e2[i]) > m) m = mag(e2[i]);
            end
            while ((m >> s) >= (64'd1 << 30)) s++;
            for (int i = 0; i < 3; i++) begin
                e1[i] = e1[i] >>> s;
                e2[i] = e2[i] >>> s;
            end
            cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
            cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
            cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
            // drop degenerate faces
            if (!unit_vec(cr[0], cr[1], cr[2], nx, ny, nz)) return;
            idx[0] = a; idx[1] = b; idx[2] = c;
            for (int i = 0; i < 3; i++) begin
                k = idx[i];
                acc_mem[k].x = sat_add(acc_mem[k].x, nx);
                acc_mem[k].y = sat_add(acc_mem[k].y, ny);
                acc_mem[k].z = sat_add(acc_mem[k].z, nz);
            end
        endfunction

        // Apply one accepted command to the predicted state
        function void note_command(t_in_item it);
            t_out_item r;
            case (it.kind)
                K_WRITE: begin
                    pos_mem[it.vtx_id] = '{it.pos_x, it.pos_y, it.pos_z};
                end
                K_TRI: begin
                    add_face(it.corner_a, it.corner_b, it.corner_c);
                end
                K_READ: begin
                    r.vertex_out = it.vtx_id;
                    r.zero_normal = !unit_vec(acc_mem[it.vtx_id].x,
                        acc_mem[it.vtx_id].y, acc_mem[it.vtx_id].z,
                        r.normal_x, r.normal_y, r.normal_z);
                    normal_q.insert(normal_q.size(), r);
                end
                default: begin
                    foreach (acc_mem[i]) acc_mem[i] = '0;
                end
            endcase
        endfunction

        function void check_normal(t_out_item act);
            t_out_item exp;
            if (normal_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, act);
                errors++;
                return;
            end
            exp = normal_q.pop_front();
            if (act.vertex_out !== exp.vertex_out) begin
                $display("%0t: vertex_out expected %0d actual %0d", $time,
                         exp.vertex_out, act.vertex_out);
                errors++;
            end
            if (act.normal_x !== exp.normal_x) begin
                $display("%0t: normal_x expected %0d actual %0d", $time,
                         exp.normal_x, act.normal_x);
                errors++;
            end
            if (act.normal_y !== exp.normal_y) begin
                $display("%0t: normal_y expected %0d actual %0d", $time,
                         exp.normal_y, act.normal_y);
                errors++;
            end
            if (act.normal_z !== exp.normal_z) begin
                $display("%0t: normal_z expected %0d actual %0d", $time,
                         exp.normal_z, act.normal_z);
                errors++;
            end
            if (act.zero_normal !== exp.zero_normal) begin
                $display("%0t: zero_normal expected %0b actual %0b", $time,
                         exp.zero_normal, act.zero_normal);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_item;
    logic      busy;
    logic      o_done;
    t_out_item o_result;

    normal_scoreboard sb;
    int                written_q[$];
    int                pool_q[$];

    smooth_vertex_normal_accumulator u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Check every result strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_normal(o_result);
    end

    // Hold the command until a transfer happens
    task automatic issue(t_in_item it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_command(it);
        if (it.kind == K_WRITE) written_q.insert(written_q.size(), it.vtx_id);
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.normal_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in_item noise_item();
        t_in_item it;
        it.kind         = 2'($urandom);
        it.vtx_id       = 12'($urandom);
        it.pos_x        = $urandom;
        it.pos_y        = $urandom;
        it.pos_z        = $urandom;
        it.corner_a     = 12'($urandom);
        it.corner_b     = 12'($urandom);
        it.corner_c     = 12'($urandom);
        return it;
    endfunction

    function automatic t_in_item mk_write(int v, int x, int y, int z);
        t_in_item it;
        it = noise_item();
        it.kind = K_WRITE;
        it.vtx_id = 12'(v);
        it.pos_x = x; it.pos_y = y; it.pos_z = z;
        return it;
    endfunction

    function automatic t_in_item mk_tri(int a, int b, int c);
        t_in_item it;
        it = noise_item();
        it.kind = K_TRI;
        it.corner_a = 12'(a); it.corner_b = 12'(b); it.corner_c = 12'(c);
        return it;
    endfunction

    function automatic t_in_item mk_op(logic [1:0] k, int v);
        t_in_item it;
        it = noise_item();
        it.kind = k;
        it.vtx_id = 12'(v);
        return it;
    endfunction

    function automatic int rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return $urandom_range(0, 2 << 20) - (1 << 20);
        if (sel < 8) return $urandom;
        return (sel == 8) ? 32'h7fff_ffff : 32'h8000_0000;
    endfunction

    function automatic int pick_written();
        return written_q[$urandom_range(0, written_q.size() - 1)];
    endfunction

    initial begin
        int       sel, a, b, c, v, n_items;
        sb      = new();
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every kind, degenerate faces, zero reads
        issue(mk_op(K_READ, 5));
        issue(mk_write(4095, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        issue(mk_write(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        issue(mk_write(1, 0, 0, 0));
        issue(mk_write(2, 1 << 16, 0, 0));
        issue(mk_write(3, 0, 1 << 16, 0));
        issue(mk_write(6, 2 << 16, 0, 0));
        issue(mk_write(7, 32'h7fff_ffff, 32'h8000_0000, 12345));
        issue(mk_tri(1, 2, 3));
        issue(mk_tri(1, 2, 2));
        issue(mk_tri(1, 2, 6));
        issue(mk_tri(0, 4095, 7));
        issue(mk_tri(0, 7, 2));
        issue(mk_op(K_READ, 1));
        issue(mk_op(K_READ, 2));
        issue(mk_op(K_READ, 0));
        issue(mk_op(K_READ, 4095));
        issue(mk_op(K_READ, 6));
        issue(mk_op(K_CLEAR, 0));
        issue(mk_op(K_READ, 1));
        issue(mk_tri(1, 3, 2));
        issue(mk_op(K_READ, 3));
        drain();

        // Saturate the accumulators of one face
        issue(mk_op(K_CLEAR, 0));
        for (int i = 0; i < 520; i++) issue(mk_tri(1, 2, 3));
        issue(mk_op(K_READ, 1));
        issue(mk_op(K_READ, 2));

        // Pool of vertices spread over the index range
        for (int i = 0; i < 24; i++) pool_q.insert(pool_q.size(), $urandom_range(0, 4095));
        foreach (pool_q[i]) issue(mk_write(pool_q[i], rand_coord(), rand_coord(), rand_coord()));

        n_items = 500;
        for (int i = 0; i < n_items; i++) begin
            // Random idle bursts, none near the end
            if (i < n_items - 60 && $urandom_range(0, 3) == 0) pause($urandom_range(1, 6));
            if (i == n_items / 2) drain();
            sel = $urandom_range(0, 99);
            if (sel < 25) begin
                v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                : pool_q[$urandom_range(0, 23)];
                issue(mk_write(v, rand_coord(), rand_coord(), rand_coord()));
            end else if (sel < 70) begin
                a = pick_written();
                b = pick_written();
                c = ($urandom_range(0, 9) == 0) ? a : pick_written();
                issue(mk_tri(a, b, c));
            end else if (sel < 98) begin
                v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                : pool_q[$urandom_range(0, 23)];
                issue(mk_op(K_READ, v));
            end else begin
                issue(mk_op(K_CLEAR, 0));
            end
        end

        // Wait out outstanding results and trailing work
        drain();
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Timeout
    initial begin
        #36000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
